>>> rtl/core/rxc_pkg.sv
// package for the run-length / xor chain stream encoder
// item types, kind codes and shared constants; no dependencies
`default_nettype none

package rxc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SUM_W  = 32;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned CNT_W  = 4;
	localparam int unsigned IDX_W  = 3;

	localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

	// kind codes, codes 5 to 7 are ignored
	localparam logic [KIND_W-1:0] KIND_START = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RAW   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CELL  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SUMS  = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] value;
		logic              use_mask;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} out_item_t;

	// byte selection result for the item being worked on
	typedef struct packed {
		logic [BYTE_W-1:0] plain;
		logic [CNT_W-1:0]  count;
		logic              last;
		logic [BYTE_W-1:0] grid_byte;
		logic              mismatch;
		logic [SUM_W-1:0]  word;
	} sel_t;

endpackage

`default_nettype wire

>>> rtl/core/rxc_byte_sel.sv
// picks the plain byte for the current byte slot of the held item
// depends on rxc_pkg
`default_nettype none

module rxc_byte_sel (
	input  rxc_pkg::in_item_t                  item,
	input  logic [rxc_pkg::IDX_W-1:0]          idx,
	input  logic [rxc_pkg::BYTE_W-1:0]         cell_mask,
	input  logic [rxc_pkg::BYTE_W-1:0]         run_length,
	input  logic [rxc_pkg::BYTE_W-1:0]         run_symbol,
	input  logic [rxc_pkg::SUM_W-1:0]          value_sum,
	input  logic [rxc_pkg::SUM_W-1:0]          coded_sum,
	input  logic [rxc_pkg::SUM_W-1:0]          word_q,
	output rxc_pkg::sel_t                      sel
);
	import rxc_pkg::*;

	logic [BYTE_W-1:0] grid_byte;
	logic              mismatch;
	logic [SUM_W-1:0]  word;
	logic [BYTE_W-1:0] word_byte;
	logic [BYTE_W-1:0] plain;
	logic [CNT_W-1:0]  count;

	assign grid_byte = item.use_mask ? (item.value & cell_mask) : item.value;
	assign mismatch  = (grid_byte != run_symbol) || (run_length == BYTE_MAX);

	// each sum word is sampled live on its first byte, then held
	always_comb begin
		if (idx == IDX_W'(0)) begin
			word = value_sum;
		end else if (idx == IDX_W'(4)) begin
			word = coded_sum;
		end else begin
			word = word_q;
		end
	end

	always_comb begin
		unique case (idx[1:0])
			2'd0: word_byte = word[7:0];
			2'd1: word_byte = word[15:8];
			2'd2: word_byte = word[23:16];
			2'd3: word_byte = word[31:24];
			default: word_byte = word[7:0];
		endcase
	end

	always_comb begin
		priority if (item.kind == KIND_START || item.kind == KIND_RAW) begin
			plain = item.value;
			count = CNT_W'(1);
		end else if (item.kind == KIND_CELL) begin
			plain = idx[0] ? run_symbol : run_length;
			count = mismatch ? CNT_W'(2) : CNT_W'(0);
		end else if (item.kind == KIND_END) begin
			plain = idx[0] ? run_symbol : run_length;
			count = (run_length != '0) ? CNT_W'(2) : CNT_W'(0);
		end else if (item.kind == KIND_SUMS) begin
			plain = word_byte;
			count = CNT_W'(8);
		end else begin
			plain = item.value;
			count = CNT_W'(0);
		end
	end

	assign sel.plain     = plain;
	assign sel.count     = count;
	assign sel.last      = ({1'b0, idx} == (count - CNT_W'(1)));
	assign sel.grid_byte = grid_byte;
	assign sel.mismatch  = mismatch;
	assign sel.word      = word;

endmodule

`default_nettype wire

>>> rtl/core/rxc_out_stage.sv
// output register holding one result item toward the consumer
// depends on rxc_pkg
`default_nettype none

module rxc_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  rxc_pkg::out_item_t load_item,
	output logic               ready,
	output logic               out_valid,
	input  logic               out_stall,
	output rxc_pkg::out_item_t out_item
);
	import rxc_pkg::*;

	logic      valid_q;
	out_item_t item_q;

	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			item_q <= load_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rle_xor_chain_stream_encoder_core.sv
// top level of the run-length / xor chain stream encoder
// depends on rxc_pkg, rxc_byte_sel and rxc_out_stage
`default_nettype none

// Byte stream encoder. Every plain byte is folded into an 8-bit xor chain
// and the new chain value is emitted; a start item emits its seed and
// restarts the chain, sums and run. Grid cells (optionally ANDed with
// cell_mask) are run-length coded into count/value pairs, runs capped at
// 255; end of grid flushes a nonzero run. A checksum item emits the value
// sum then the coded sum, 4 bytes each, low byte first. Each item sits in
// an input register and emits one byte per cycle into an output register
// whenever that register can take it; its byte count is 0, 1, 2 or 8,
// and the single xor chain and sum adders produce one byte a cycle. The
// next item is taken in the cycle the current one issues its last byte, or
// at once if it has none, also while that byte waits in the output register.
// last marks the final byte of each item. cell_mask resets to 0xFF.

module rle_xor_chain_stream_encoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rxc_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output rxc_pkg::out_item_t            out_item,
	input  logic                          cfg_wr_en,
	input  logic [rxc_pkg::BYTE_W-1:0]    cfg_wr_data
);
	import rxc_pkg::*;

	// held item and its byte slot
	logic              valid_s1;
	in_item_t          item_s1;
	logic [IDX_W-1:0]  idx_q;

	// encoder state
	logic [BYTE_W-1:0] cell_mask_q;
	logic [BYTE_W-1:0] xor_chain_q;
	logic [SUM_W-1:0]  value_sum_q;
	logic [SUM_W-1:0]  coded_sum_q;
	logic [BYTE_W-1:0] run_length_q;
	logic [BYTE_W-1:0] run_symbol_q;
	logic [SUM_W-1:0]  word_q;

	sel_t              sel;
	logic              out_ready;
	logic              step;
	logic              item_done;
	logic              accept;
	logic [BYTE_W-1:0] chain_next;
	out_item_t         load_item;

	rxc_byte_sel u_sel (
		.item       (item_s1),
		.idx        (idx_q),
		.cell_mask  (cell_mask_q),
		.run_length (run_length_q),
		.run_symbol (run_symbol_q),
		.value_sum  (value_sum_q),
		.coded_sum  (coded_sum_q),
		.word_q     (word_q),
		.sel        (sel)
	);

	// a start item chains its seed into a cleared chain
	assign chain_next = (item_s1.kind == KIND_START) ? sel.plain : (xor_chain_q ^ sel.plain);

	// one byte leaves whenever the output register can take it
	assign step      = valid_s1 && (sel.count != '0) && out_ready;
	// items with no bytes finish at once, without waiting on the output register
	assign item_done = valid_s1 && ((sel.count == '0) || (out_ready && sel.last));
	assign in_stall  = valid_s1 && !item_done;
	assign accept    = in_valid && !in_stall;

	assign load_item.out_byte = chain_next;
	assign load_item.last     = sel.last;

	rxc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.load_item (load_item),
		.ready     (out_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	// sum word capture for the checksum bytes
	always_ff @(posedge clk) begin
		if (step) begin
			word_q <= sel.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_mask_q <= BYTE_MAX;
		end else if (cfg_wr_en) begin
			cell_mask_q <= cfg_wr_data;
		end
	end

	// byte slot counter, back to zero after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (step) begin
			idx_q <= sel.last ? '0 : idx_q + IDX_W'(1);
		end
	end

	// chain and sums move per byte; the start item clears sums at its end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_chain_q <= '0;
			value_sum_q <= '0;
			coded_sum_q <= '0;
		end else if (step) begin
			xor_chain_q <= chain_next;
			if (item_s1.kind == KIND_START) begin
				value_sum_q <= '0;
				coded_sum_q <= '0;
			end else begin
				value_sum_q <= value_sum_q + SUM_W'(sel.plain);
				coded_sum_q <= coded_sum_q + SUM_W'(chain_next);
			end
		end
	end

	// run state changes once the item's bytes are all out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= '0;
			run_symbol_q <= '0;
		end else if (item_done) begin
			priority if (item_s1.kind == KIND_START || item_s1.kind == KIND_END) begin
				run_length_q <= '0;
				run_symbol_q <= '0;
			end else if (item_s1.kind == KIND_CELL) begin
				if (sel.mismatch) begin
					run_length_q <= BYTE_W'(1);
					run_symbol_q <= sel.grid_byte;
				end else begin
					run_length_q <= run_length_q + BYTE_W'(1);
				end
			end else begin
				run_length_q <= run_length_q;
			end
		end
	end

endmodule

`default_nettype wire
